// File: hw/rtl/pfd_pkg.sv
// Package for the Pareto frontier filter with fingerprint de-duplication.
// Holds shared types, state encodings, hash constants and cost compare functions.
// No dependencies.
package pfd_pkg;

  localparam int METRIC_DIMS = 10;
  localparam int MET_W = 64 * METRIC_DIMS;

  localparam logic [63:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int MIX_S1 = 30;
  localparam int MIX_S2 = 27;
  localparam int MIX_S3 = 31;
  localparam logic [63:0] SIGN_BIAS = 64'h8000000000000000;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_DUP       = 3'd1,
    ST_DOMINATED = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_FULL      = 3'd4,
    ST_IGNORED   = 3'd5
  } status_t;

  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_LIST   = 1'b1
  } kind_t;

  typedef struct packed {
    logic [63:0]      fp;
    logic [MET_W-1:0] met;
    logic             last;
  } cand_t;

  typedef struct packed {
    kind_t       kind;
    status_t     status;
    logic [31:0] index;
    logic [5:0]  removed;
    logic [5:0]  fsize;
    logic [6:0]  uniq;
    logic [31:0] dup;
    logic [31:0] dom;
    logic        last;
  } res_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_CLR,
    B_IDLE,
    B_P_SLOT,
    B_P_ENT,
    B_P_CHK,
    B_MM,
    B_W1,
    B_W2,
    B_APPEND,
    B_EMIT,
    B_L1,
    B_L2,
    B_L3
  } back_state_t;

  function automatic logic dominates(input logic [MET_W-1:0] a, input logic [MET_W-1:0] b);
    logic no_worse;
    logic better;
    no_worse = 1'b1;
    better   = 1'b0;
    for (int d = 0; d < METRIC_DIMS; d++) begin
      if (a[64*d +: 64] > b[64*d +: 64]) no_worse = 1'b0;
      if (a[64*d +: 64] < b[64*d +: 64]) better = 1'b1;
    end
    return no_worse && better;
  endfunction

  function automatic logic costs_equal(input logic [MET_W-1:0] a, input logic [MET_W-1:0] b);
    return a == b;
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x != 32'hFFFFFFFF) ? x + 32'd1 : x;
  endfunction

endpackage

// File: hw/rtl/pfd_ifs.sv
// Channel interfaces for the Pareto frontier filter: candidate in, result out.
// Depends on nothing; valid/ready handshake with payload fields.
interface pfd_cand_if;
  logic               valid;
  logic               ready;
  logic [63:0]        fingerprint;
  logic signed [63:0] latency_cost;
  logic signed [63:0] preparation_cost;
  logic signed [63:0] persistent_size;
  logic signed [63:0] transient_size;
  logic signed [63:0] update_cost;
  logic signed [63:0] layout_cost;
  logic signed [63:0] forward_loss;
  logic signed [63:0] transpose_loss;
  logic signed [63:0] contraction_loss;
  logic signed [63:0] reuse_penalty;
  logic               last_candidate;

  modport source (
    output valid, fingerprint, latency_cost, preparation_cost, persistent_size,
           transient_size, update_cost, layout_cost, forward_loss, transpose_loss,
           contraction_loss, reuse_penalty, last_candidate,
    input  ready
  );
  modport sink (
    input  valid, fingerprint, latency_cost, preparation_cost, persistent_size,
           transient_size, update_cost, layout_cost, forward_loss, transpose_loss,
           contraction_loss, reuse_penalty, last_candidate,
    output ready
  );
endinterface

interface pfd_res_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [31:0] candidate_index;
  logic [5:0]  removed_count;
  logic [5:0]  frontier_size;
  logic [6:0]  unique_total;
  logic [31:0] duplicate_total;
  logic [31:0] dominated_total;
  logic        last;

  modport source (
    output valid, kind, status, candidate_index, removed_count, frontier_size,
           unique_total, duplicate_total, dominated_total, last,
    input  ready
  );
  modport sink (
    input  valid, kind, status, candidate_index, removed_count, frontier_size,
           unique_total, duplicate_total, dominated_total, last,
    output ready
  );
endinterface

// File: hw/rtl/pareto_frontier_dedup_filter.sv
// Pareto frontier filter with fingerprint de-duplication, top level.
// The front end hashes each candidate; the back end takes probe steps, then two walks over
// the frontier members, plus one step per listing entry.
// One candidate is in the back end at a time; the queue lets the next one be hashed meanwhile.
// Reset is synchronous; after reset a clearing pass sweeps the slot table
// and no candidate is taken until it ends. Depends on pfd_pkg, pfd_ifs and the submodules.
module pareto_frontier_dedup_filter
  import pfd_pkg::*;
#(
  parameter int HASH_SLOTS = 64,
  parameter int FRONTIER_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  pfd_cand_if.sink   cand,
  pfd_res_if.source  res
);

  localparam int SW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1;
  localparam int QW = $bits(cand_t) + SW;

  logic          clearing;
  logic          f_valid;
  logic          f_ready;
  cand_t         f_item;
  logic [SW-1:0] f_start;
  logic          q_valid;
  logic          q_ready;
  logic [QW-1:0] q_data;
  logic          rb_valid;
  res_t          rb;

  pfd_front #(.HASH_SLOTS(HASH_SLOTS)) u_front (
    .clk(clk), .rst(rst), .en(!clearing), .cand(cand),
    .q_valid(f_valid), .q_ready(f_ready), .q_item(f_item), .q_start(f_start)
  );

  pfd_queue #(.W(QW)) u_queue (
    .clk(clk), .rst(rst),
    .in_valid(f_valid), .in_ready(f_ready), .in_data({f_item, f_start}),
    .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
  );

  pfd_back #(.HASH_SLOTS(HASH_SLOTS), .FRONTIER_DEPTH(FRONTIER_DEPTH)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_item(cand_t'(q_data[QW-1:SW])),
    .q_start(q_data[SW-1:0]), .clearing(clearing),
    .res_valid(rb_valid), .res_ready(res.ready), .res(rb)
  );

  assign res.valid           = rb_valid;
  assign res.kind            = rb.kind;
  assign res.status          = rb.status;
  assign res.candidate_index = rb.index;
  assign res.removed_count   = rb.removed;
  assign res.frontier_size   = rb.fsize;
  assign res.unique_total    = rb.uniq;
  assign res.duplicate_total = rb.dup;
  assign res.dominated_total = rb.dom;
  assign res.last            = rb.last;

  a_clr_no_accept: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !cand.ready)
    else $error("candidate taken during slot table clear");

  a_clr_no_pop: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !(q_valid && q_ready))
    else $error("queue popped during slot table clear");

  a_list_entry: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.kind) |->
      (res.status == ST_ADDED && res.removed_count == 6'd0 && res.frontier_size != 6'd0))
    else $error("malformed frontier listing entry");

endmodule

// File: hw/rtl/pfd_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module pfd_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/pfd_queue.sv
// Two-item queue that decouples the hashing front from the frontier back end.
// No dependencies.
module pfd_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_data,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_data
);

  logic [W-1:0] mem [2];
  logic         wp;
  logic         rp;
  logic [1:0]   cnt;
  logic         push;
  logic         pop;

  assign in_ready  = cnt != 2'd2;
  assign out_valid = cnt != 2'd0;
  assign out_data  = mem[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: hw/rtl/pfd_front.sv
// Front end: accepts a candidate, mixes its fingerprint and reduces it to a start slot.
// Depends on pfd_pkg and pfd_cand_if.
module pfd_front
  import pfd_pkg::*;
#(
  parameter int HASH_SLOTS = 64,
  localparam int SW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1,
  localparam int RW = $clog2(HASH_SLOTS) + 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  pfd_cand_if.sink      cand,
  output logic          q_valid,
  input  logic          q_ready,
  output cand_t         q_item,
  output logic [SW-1:0] q_start
);

  front_state_t  state;
  front_state_t  state_next;
  logic [63:0]   v;
  logic [63:0]   acc;
  logic [1:0]    mcnt;
  logic          rnd;
  logic [RW-1:0] r;
  logic [RW-1:0] r_next;
  logic [3:0]    dcnt;
  cand_t         item;
  logic [SW-1:0] start;
  logic [63:0]   c;
  logic [31:0]   op_a;
  logic [31:0]   op_b;
  logic [63:0]   prod;
  logic [63:0]   mixed;
  logic [63:0]   folded;
  logic          accept;

  assign cand.ready = (state == F_IDLE) && en;
  assign accept     = cand.valid && cand.ready;
  assign q_valid    = state == F_PUSH;
  assign q_item     = item;
  assign q_start    = start;

  assign c = rnd ? MIX_C2 : MIX_C1;

  always_comb begin
    case (mcnt)
      2'd0: begin
        op_a = v[31:0];
        op_b = c[31:0];
      end
      2'd1: begin
        op_a = v[31:0];
        op_b = c[63:32];
      end
      default: begin
        op_a = v[63:32];
        op_b = c[31:0];
      end
    endcase
  end

  assign prod   = op_a * op_b;
  assign mixed  = {acc[63:32] + prod[31:0], acc[31:0]};
  assign folded = rnd ? (mixed ^ (mixed >> MIX_S3)) : (mixed ^ (mixed >> MIX_S2));

  always_comb begin
    logic [RW-1:0] t;
    r_next = r;
    for (int k = 0; k < 4; k++) begin
      t = (r_next << 1) | RW'(v[63-k]);
      r_next = (t >= RW'(HASH_SLOTS)) ? t - RW'(HASH_SLOTS) : t;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      F_IDLE:  if (accept) state_next = F_MUL;
      F_MUL:   if (mcnt == 2'd2 && rnd) state_next = F_MOD;
      F_MOD:   if (dcnt == 4'd15) state_next = F_PUSH;
      F_PUSH:  if (q_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          item.fp   <= cand.fingerprint;
          item.last <= cand.last_candidate;
          item.met  <= {cand.reuse_penalty ^ SIGN_BIAS, cand.contraction_loss ^ SIGN_BIAS,
                        cand.transpose_loss ^ SIGN_BIAS, cand.forward_loss ^ SIGN_BIAS,
                        cand.layout_cost ^ SIGN_BIAS, cand.update_cost ^ SIGN_BIAS,
                        cand.transient_size ^ SIGN_BIAS, cand.persistent_size ^ SIGN_BIAS,
                        cand.preparation_cost ^ SIGN_BIAS, cand.latency_cost ^ SIGN_BIAS};
          v    <= cand.fingerprint ^ (cand.fingerprint >> MIX_S1);
          mcnt <= 2'd0;
          rnd  <= 1'b0;
        end
      end
      F_MUL: begin
        case (mcnt)
          2'd0:    acc <= prod;
          2'd1:    acc[63:32] <= acc[63:32] + prod[31:0];
          default: begin
            v <= folded;
            rnd <= 1'b1;
          end
        endcase
        mcnt <= (mcnt == 2'd2) ? 2'd0 : mcnt + 2'd1;
        r    <= '0;
        dcnt <= 4'd0;
      end
      F_MOD: begin
        r    <= r_next;
        v    <= v << 4;
        dcnt <= dcnt + 4'd1;
        if (dcnt == 4'd15) start <= r_next[SW-1:0];
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/pfd_back.sv
// Back end: probes the slot table, checks duplicates, walks the frontier twice and emits results.
// Depends on pfd_pkg and pfd_ram.
module pfd_back
  import pfd_pkg::*;
#(
  parameter int HASH_SLOTS = 64,
  parameter int FRONTIER_DEPTH = 32,
  localparam int SW = (HASH_SLOTS > 1) ? $clog2(HASH_SLOTS) : 1,
  localparam int UW = $clog2(HASH_SLOTS + 1),
  localparam int FW = $clog2(FRONTIER_DEPTH + 1),
  localparam int FAW = (FRONTIER_DEPTH > 1) ? $clog2(FRONTIER_DEPTH) : 1,
  localparam int EW = 64 + SW + 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_ready,
  input  cand_t         q_item,
  input  logic [SW-1:0] q_start,
  output logic          clearing,
  output logic          res_valid,
  input  logic          res_ready,
  output res_t          res
);

  back_state_t   state;
  back_state_t   state_next;
  cand_t         cur;
  logic [31:0]   pos;
  logic [SW-1:0] s;
  logic [SW-1:0] s_next;
  logic [SW-1:0] pcnt;
  logic [SW-1:0] e_reg;
  logic [SW-1:0] ecur;
  logic [SW-1:0] clr;
  logic [SW-1:0] e2;
  logic [FW-1:0] fc;
  logic [FW-1:0] iss;
  logic [FW-1:0] kept;
  logic [FW-1:0] removed;
  logic [FW-1:0] lf;
  logic          v1;
  logic          v2;
  logic [UW-1:0] uniq;
  logic [31:0]   dup;
  logic [31:0]   dom;
  logic [31:0]   bidx;
  logic          err;
  status_t       st;

  logic             slot_we;
  logic [SW-1:0]    slot_waddr;
  logic [SW-1:0]    slot_wdata;
  logic [SW-1:0]    slot_rdata;
  logic             ent_we;
  logic [SW-1:0]    ent_raddr;
  logic [EW-1:0]    ent_rdata;
  logic             met_we;
  logic [SW-1:0]    met_raddr;
  logic [MET_W-1:0] met_rdata;
  logic             fl_we;
  logic [FAW-1:0]   fl_waddr;
  logic [SW-1:0]    fl_wdata;
  logic [FAW-1:0]   fl_raddr;
  logic [SW-1:0]    fl_rdata;

  logic [63:0]   ent_fp;
  logic [SW-1:0] ent_slot;
  logic [31:0]   ent_pos;
  logic          hit_valid;
  logic          fp_eq;
  logic          tbl_full;
  logic          probe_last;
  logic          walk_done;
  logic          dom_hit;
  logic          beaten;
  logic          listing;
  logic          lf_last;
  logic          ofree;
  logic          o_load;
  res_t          o_next;

  pfd_ram #(.W(SW), .D(HASH_SLOTS)) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(s), .rdata(slot_rdata)
  );

  pfd_ram #(.W(EW), .D(HASH_SLOTS)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(uniq[SW-1:0]), .wdata({cur.fp, s, pos}),
    .raddr(ent_raddr), .rdata(ent_rdata)
  );

  pfd_ram #(.W(MET_W), .D(HASH_SLOTS)) u_met_ram (
    .clk(clk), .we(met_we), .waddr(uniq[SW-1:0]), .wdata(cur.met),
    .raddr(met_raddr), .rdata(met_rdata)
  );

  pfd_ram #(.W(SW), .D(FRONTIER_DEPTH)) u_fl_ram (
    .clk(clk), .we(fl_we), .waddr(fl_waddr), .wdata(fl_wdata),
    .raddr(fl_raddr), .rdata(fl_rdata)
  );

  assign ent_fp     = ent_rdata[EW-1 -: 64];
  assign ent_slot   = ent_rdata[SW+31:32];
  assign ent_pos    = ent_rdata[31:0];
  assign hit_valid  = (UW'(e_reg) < uniq) && (ent_slot == s);
  assign fp_eq      = ent_fp == cur.fp;
  assign tbl_full   = uniq >= UW'(HASH_SLOTS);
  assign probe_last = pcnt == SW'(HASH_SLOTS - 1);
  assign s_next     = (s == SW'(HASH_SLOTS - 1)) ? '0 : s + 1'b1;
  assign walk_done  = (iss == fc) && !v1 && !v2;
  assign dom_hit    = dominates(met_rdata, cur.met) || costs_equal(met_rdata, cur.met);
  assign beaten     = dominates(cur.met, met_rdata);
  assign listing    = cur.last && !err && (fc != '0);
  assign lf_last    = FW'(lf + 1'b1) == fc;
  assign ofree      = !res_valid || res_ready;
  assign clearing   = state == B_CLR;

  always_comb begin
    state_next = state;
    q_ready    = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = s;
    slot_wdata = uniq[SW-1:0];
    ent_we     = 1'b0;
    ent_raddr  = slot_rdata;
    met_we     = 1'b0;
    met_raddr  = fl_rdata;
    fl_we      = 1'b0;
    fl_waddr   = kept[FAW-1:0];
    fl_wdata   = e2;
    fl_raddr   = iss[FAW-1:0];
    o_load     = 1'b0;
    o_next     = '0;
    case (state)
      B_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr;
        slot_wdata = '0;
        if (clr == SW'(HASH_SLOTS - 1)) state_next = B_IDLE;
      end
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) state_next = err ? B_EMIT : B_P_SLOT;
      end
      B_P_SLOT: state_next = B_P_ENT;
      B_P_ENT:  state_next = B_P_CHK;
      B_P_CHK: begin
        met_raddr = e_reg;
        if (!hit_valid) begin
          if (tbl_full) begin
            state_next = B_EMIT;
          end else begin
            slot_we    = 1'b1;
            ent_we     = 1'b1;
            met_we     = 1'b1;
            state_next = B_W1;
          end
        end else if (fp_eq) begin
          state_next = B_MM;
        end else if (probe_last) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_P_SLOT;
        end
      end
      B_MM: state_next = B_EMIT;
      B_W1: begin
        if (v2 && dom_hit) state_next = B_EMIT;
        else if (walk_done) state_next = B_W2;
      end
      B_W2: begin
        if (v2 && !beaten) fl_we = 1'b1;
        if (walk_done) state_next = B_APPEND;
      end
      B_APPEND: begin
        if (kept < FW'(FRONTIER_DEPTH)) begin
          fl_we    = 1'b1;
          fl_wdata = ecur;
        end
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (ofree) begin
          o_load         = 1'b1;
          o_next.kind    = KIND_STATUS;
          o_next.status  = st;
          o_next.index   = pos;
          o_next.removed = 6'(removed);
          o_next.fsize   = 6'(fc);
          o_next.uniq    = 7'(uniq);
          o_next.dup     = dup;
          o_next.dom     = dom;
          o_next.last    = cur.last && !listing;
          state_next     = listing ? B_L1 : B_IDLE;
        end
      end
      B_L1: begin
        fl_raddr   = lf[FAW-1:0];
        state_next = B_L2;
      end
      B_L2: begin
        fl_raddr   = lf[FAW-1:0];
        ent_raddr  = fl_rdata;
        state_next = B_L3;
      end
      B_L3: begin
        fl_raddr  = lf[FAW-1:0];
        ent_raddr = fl_rdata;
        if (ofree) begin
          o_load         = 1'b1;
          o_next.kind    = KIND_LIST;
          o_next.status  = ST_ADDED;
          o_next.index   = ent_pos;
          o_next.removed = '0;
          o_next.fsize   = 6'(fc);
          o_next.uniq    = 7'(uniq);
          o_next.dup     = dup;
          o_next.dom     = dom;
          o_next.last    = lf_last;
          state_next     = lf_last ? B_IDLE : B_L1;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_CLR;
    else state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr       <= '0;
      fc        <= '0;
      uniq      <= '0;
      dup       <= '0;
      dom       <= '0;
      bidx      <= '0;
      err       <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (o_load) begin
        res_valid <= 1'b1;
        res       <= o_next;
      end
      case (state)
        B_CLR: clr <= clr + 1'b1;
        B_IDLE: begin
          if (q_valid) begin
            cur     <= q_item;
            s       <= q_start;
            pcnt    <= '0;
            pos     <= bidx;
            bidx    <= sat_inc(bidx);
            removed <= '0;
            if (err) st <= ST_IGNORED;
          end
        end
        B_P_ENT: e_reg <= slot_rdata;
        B_P_CHK: begin
          if (!hit_valid) begin
            if (tbl_full) begin
              st  <= ST_FULL;
              err <= 1'b1;
            end else begin
              ecur <= uniq[SW-1:0];
              uniq <= uniq + 1'b1;
              iss  <= '0;
              v1   <= 1'b0;
              v2   <= 1'b0;
            end
          end else if (!fp_eq) begin
            if (probe_last) begin
              st  <= ST_FULL;
              err <= 1'b1;
            end else begin
              pcnt <= pcnt + 1'b1;
              s    <= s_next;
            end
          end
        end
        B_MM: begin
          if (costs_equal(met_rdata, cur.met)) begin
            dup <= sat_inc(dup);
            st  <= ST_DUP;
          end else begin
            st  <= ST_MISMATCH;
            err <= 1'b1;
          end
        end
        B_W1, B_W2: begin
          if (iss < fc) begin
            iss <= iss + 1'b1;
            v1  <= 1'b1;
          end else begin
            v1 <= 1'b0;
          end
          v2 <= v1;
          e2 <= fl_rdata;
          if (v2) begin
            if (state == B_W1) begin
              if (dom_hit) begin
                dom <= sat_inc(dom);
                st  <= ST_DOMINATED;
              end
            end else if (beaten) begin
              dom     <= sat_inc(dom);
              removed <= removed + 1'b1;
            end else begin
              kept <= kept + 1'b1;
            end
          end
          if (walk_done) begin
            iss <= '0;
            if (state == B_W1) kept <= '0;
          end
        end
        B_APPEND: begin
          if (kept < FW'(FRONTIER_DEPTH)) begin
            fc <= kept + 1'b1;
            st <= ST_ADDED;
          end else begin
            fc  <= kept;
            st  <= ST_FULL;
            err <= 1'b1;
          end
        end
        B_EMIT: begin
          if (ofree) begin
            lf <= '0;
            if (cur.last && !listing) begin
              fc   <= '0;
              uniq <= '0;
              dup  <= '0;
              dom  <= '0;
              bidx <= '0;
              err  <= 1'b0;
            end
          end
        end
        B_L3: begin
          if (ofree) begin
            lf <= lf + 1'b1;
            if (lf_last) begin
              fc   <= '0;
              uniq <= '0;
              dup  <= '0;
              dom  <= '0;
              bidx <= '0;
              err  <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// File: tb/pfd_tb_ifs.sv
`timescale 1ns / 100ps
// Testbench-side helpers for the Pareto frontier filter channels.
// Depends on pfd_pkg; the channel interfaces come from the RTL file pfd_ifs.sv.
package pfd_tb_pkg;
  import pfd_pkg::*;

  typedef struct {
    logic [63:0] fp;
    logic [63:0] met [10];
    logic        last;
  } cand_item_t;

  typedef struct {
    kind_t       kind;
    status_t     status;
    logic [31:0] index;
    logic [5:0]  removed;
    logic [5:0]  fsize;
    logic [6:0]  uniq;
    logic [31:0] dup;
    logic [31:0] dom;
    logic        last;
  } result_item_t;
endpackage

// File: tb/pareto_frontier_dedup_filter_test.sv
`timescale 1ns / 100ps
// Testbench for pareto_frontier_dedup_filter: directed table, a receiver hold, then random batches,
// each result checked against a skyline/dedup predictor. Depends on pfd_pkg, pfd_ifs, pfd_tb_pkg.
module pareto_frontier_dedup_filter_test;
  import pfd_pkg::*;
  import pfd_tb_pkg::*;

  localparam int SLOTS = 64;
  localparam int DEPTH = 32;
  localparam longint LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #6 clk = ~clk;

  pfd_cand_if cand ();
  pfd_res_if  res ();

  pareto_frontier_dedup_filter #(.HASH_SLOTS(SLOTS), .FRONTIER_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .cand(cand.sink), .res(res.source)
  );

  // predictor state
  logic [6:0]  slot_map [SLOTS];
  logic [63:0] ent_fp [SLOTS];
  logic [63:0] ent_met [SLOTS][10];
  logic [31:0] ent_pos [SLOTS];
  int          front [DEPTH];
  int          front_n, uniq_n;
  logic [31:0] dup_n, dom_n, pos_n;
  bit          err_sticky;

  result_item_t expected_results [$];
  int  mismatches = 0;
  bit  quiet_tail = 0;
  bit  hold_sink = 0;
  bit  typed_en = 0;
  status_t typed_st = ST_ADDED;
  longint cycles = 0;

  function automatic logic [63:0] mix(logic [63:0] v);
    v = v ^ (v >> 30);
    v = v * 64'hbf58476d1ce4e5b9;
    v = v ^ (v >> 27);
    v = v * 64'h94d049bb133111eb;
    return v ^ (v >> 31);
  endfunction

  function automatic bit better_than(logic [63:0] a [10], logic [63:0] b [10]);
    bit strict;
    strict = 0;
    for (int d = 0; d < 10; d++) begin
      if (a[d] > b[d]) return 0;
      if (a[d] < b[d]) strict = 1;
    end
    return strict;
  endfunction

  function automatic logic [31:0] inc_sat(logic [31:0] x);
    return (x != 32'hFFFFFFFF) ? x + 1 : x;
  endfunction

  function automatic void clear_batch();
    foreach (slot_map[i]) slot_map[i] = '0;
    front_n = 0; uniq_n = 0; dup_n = 0; dom_n = 0; pos_n = 0; err_sticky = 0;
  endfunction

  function automatic void push_result(kind_t k, status_t s, logic [31:0] idx,
                                      int rm, bit lst);
    result_item_t r;
    r.kind = k; r.status = s; r.index = idx; r.removed = rm[5:0];
    r.fsize = front_n[5:0]; r.uniq = uniq_n[6:0]; r.dup = dup_n; r.dom = dom_n;
    r.last = lst;
    expected_results.push_back(r);
  endfunction

  function automatic status_t place_on_front(logic [63:0] m [10], int e, ref int rm);
    int kept;
    for (int f = 0; f < front_n; f++)
      if (better_than(ent_met[front[f]], m) || ent_met[front[f]] == m) begin
        dom_n = inc_sat(dom_n);
        return ST_DOMINATED;
      end
    kept = 0;
    for (int f = 0; f < front_n; f++)
      if (better_than(m, ent_met[front[f]])) begin
        dom_n = inc_sat(dom_n);
        rm++;
      end else begin
        front[kept++] = front[f];
      end
    front_n = kept;
    if (kept >= DEPTH) begin
      err_sticky = 1;
      return ST_FULL;
    end
    front[front_n++] = e;
    return ST_ADDED;
  endfunction

  function automatic status_t filter_candidate(cand_item_t c, logic [63:0] m [10],
                                               logic [31:0] pos, ref int rm);
    int start, s, e;
    start = int'(mix(c.fp) % SLOTS);
    for (int p = 0; p < SLOTS; p++) begin
      s = (start + p) % SLOTS;
      if (slot_map[s] == 0) begin
        e = uniq_n;
        if (e >= SLOTS) break;
        slot_map[s] = 7'(e + 1);
        ent_fp[e] = c.fp; ent_met[e] = m; ent_pos[e] = pos;
        uniq_n = e + 1;
        return place_on_front(m, e, rm);
      end
      e = (slot_map[s] - 1) % SLOTS;
      if (ent_fp[e] == c.fp) begin
        if (ent_met[e] != m) begin
          err_sticky = 1;
          return ST_MISMATCH;
        end
        dup_n = inc_sat(dup_n);
        return ST_DUP;
      end
    end
    err_sticky = 1;
    return ST_FULL;
  endfunction

  function automatic void predict_results(cand_item_t c);
    logic [63:0] m [10];
    logic [31:0] pos;
    int rm;
    status_t st;
    bit listing;
    foreach (m[d]) m[d] = c.met[d] ^ SIGN_BIAS;
    pos = pos_n;
    pos_n = inc_sat(pos_n);
    rm = 0;
    st = err_sticky ? ST_IGNORED : filter_candidate(c, m, pos, rm);
    if (typed_en && st != typed_st) begin
      mismatches++;
      if (mismatches <= 10)
        $display("typed status mismatch idx %0d exp s%0d predicted s%0d",
                 pos, typed_st, st);
    end
    listing = c.last && !err_sticky && front_n > 0;
    push_result(KIND_STATUS, st, pos, rm, c.last && !listing);
    if (listing)
      for (int f = 0; f < front_n; f++)
        push_result(KIND_LIST, ST_ADDED, ent_pos[front[f]], 0, f + 1 == front_n);
    if (c.last) clear_batch();
  endfunction

  // stimulus
  cand_item_t  stim [$];
  logic [63:0] fp_pool [$];

  function automatic cand_item_t make_cand(logic [63:0] fp, logic [63:0] base, bit lst);
    cand_item_t c;
    c.fp = fp; c.last = lst;
    foreach (c.met[d]) c.met[d] = base;
    return c;
  endfunction

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // candidates near one another so domination and ties are frequent
  function automatic cand_item_t rand_cand(bit lst);
    cand_item_t c;
    int pick;
    c.last = lst;
    pick = $urandom_range(0, 9);
    if (pick == 0 || fp_pool.size() == 0) c.fp = rnd64();
    else if (pick < 3) c.fp = fp_pool[$urandom_range(0, fp_pool.size() - 1)];
    else c.fp = {$urandom_range(0, 3), $urandom};
    foreach (c.met[d])
      c.met[d] = ($urandom_range(0, 19) == 0) ? rnd64() :
                 64'($signed($urandom_range(0, 6)) - 3);
    return c;
  endfunction

  // directed table: typed-in statuses where they are plain
  typedef struct {
    cand_item_t  c;
    bit          known;
    status_t     st;
  } dir_row_t;
  dir_row_t dir_rows [$];

  function automatic void add_row(cand_item_t c, bit known, status_t st);
    dir_row_t r;
    r.c = c; r.known = known; r.st = st;
    dir_rows.push_back(r);
  endfunction

  function automatic void build_directed();
    cand_item_t c;
    add_row(make_cand(64'h0, 64'h8000000000000000, 0), 1, ST_ADDED);
    add_row(make_cand(64'h0, 64'h8000000000000000, 0), 1, ST_DUP);
    add_row(make_cand(64'hFFFFFFFFFFFFFFFF, 64'h7FFFFFFFFFFFFFFF, 0), 1, ST_DOMINATED);
    add_row(make_cand(64'h1, 64'h8000000000000000, 0), 1, ST_DOMINATED);
    c = make_cand(64'h2, 64'h7FFFFFFFFFFFFFFF, 0);
    c.met[3] = 64'h8000000000000000;
    add_row(c, 1, ST_DOMINATED);
    c = make_cand(64'h3, 64'h0, 1);
    c.met[0] = 64'hAAAAAAAAAAAAAAAA; c.met[9] = 64'h5555555555555555;
    add_row(c, 0, ST_ADDED);
    add_row(make_cand(64'h5A5A5A5A5A5A5A5A, 64'd7, 0), 1, ST_ADDED);
    add_row(make_cand(64'h5A5A5A5A5A5A5A5A, 64'd8, 0), 1, ST_MISMATCH);
    add_row(make_cand(64'h77, 64'd1, 1), 1, ST_IGNORED);
    // frontier fill: mutually incomparable, then one more overflows
    for (int i = 0; i <= DEPTH; i++) begin
      c = make_cand(64'h1000 + i, 64'd0, i == DEPTH);
      c.met[0] = i; c.met[1] = -i;
      add_row(c, 0, ST_ADDED);
    end
    // a fresh batch: one candidate, then a dominator that removes it
    add_row(make_cand(64'hC0FFEE, 64'd5, 0), 1, ST_ADDED);
    add_row(make_cand(64'hBEEF, 64'd1, 1), 1, ST_ADDED);
  endfunction

  task automatic send_cand(cand_item_t c);
    @(negedge clk);
    cand.fingerprint      <= c.fp;
    cand.latency_cost     <= c.met[0];
    cand.preparation_cost <= c.met[1];
    cand.persistent_size  <= c.met[2];
    cand.transient_size   <= c.met[3];
    cand.update_cost      <= c.met[4];
    cand.layout_cost      <= c.met[5];
    cand.forward_loss     <= c.met[6];
    cand.transpose_loss   <= c.met[7];
    cand.contraction_loss <= c.met[8];
    cand.reuse_penalty    <= c.met[9];
    cand.last_candidate   <= c.last;
    cand.valid <= 1'b1;
    do @(posedge clk); while (!cand.ready);
    predict_results(c);
    fp_pool.push_back(c.fp);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      cand.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_item_t e;
    if (!rst && res.valid && res.ready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result kind %0d idx %0d", res.kind,
                                       res.candidate_index);
      end else begin
        e = expected_results.pop_front();
        if (res.kind !== e.kind || res.status !== e.status ||
            res.candidate_index !== e.index || res.removed_count !== e.removed ||
            res.frontier_size !== e.fsize || res.unique_total !== e.uniq ||
            res.duplicate_total !== e.dup || res.dominated_total !== e.dom ||
            res.last !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch exp k%0d s%0d i%0d r%0d f%0d u%0d d%0d m%0d l%0d",
                      " got k%0d s%0d i%0d r%0d f%0d u%0d d%0d m%0d l%0d"},
              e.kind, e.status, e.index, e.removed, e.fsize, e.uniq, e.dup, e.dom, e.last,
              res.kind, res.status, res.candidate_index, res.removed_count,
              res.frontier_size, res.unique_total, res.duplicate_total,
              res.dominated_total, res.last);
        end
      end
    end
  end

  // receiver with random stall bursts
  initial begin
    res.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_sink) begin
        res.ready <= 1'b0;
        @(negedge clk);
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
        res.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
      end else begin
        res.ready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cand_item_t c;
    int batch_len;
    cand.valid = 1'b0;
    cand.fingerprint = '0;
    cand.latency_cost = '0; cand.preparation_cost = '0; cand.persistent_size = '0;
    cand.transient_size = '0; cand.update_cost = '0; cand.layout_cost = '0;
    cand.forward_loss = '0; cand.transpose_loss = '0; cand.contraction_loss = '0;
    cand.reuse_penalty = '0; cand.last_candidate = 1'b0;
    clear_batch();
    build_directed();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      typed_en = dir_rows[i].known;
      typed_st = dir_rows[i].st;
      send_cand(dir_rows[i].c);
    end
    typed_en = 0;
    @(negedge clk);
    cand.valid <= 1'b0;
    wait (expected_results.size() == 0);

    // long receiver hold while the sender keeps offering
    fork
      begin
        hold_sink = 1;
        repeat (600) @(posedge clk);
        hold_sink = 0;
      end
      begin
        for (int i = 0; i < 30; i++) send_cand(rand_cand(i == 29));
      end
    join

    // random batches
    for (int n = 0; n < 186; ) begin
      batch_len = $urandom_range(1, 40);
      if ($urandom_range(0, 7) == 0) batch_len = $urandom_range(60, 70);
      if (batch_len > 186 - n) batch_len = 186 - n;
      for (int i = 0; i < batch_len; i++) begin
        if (n > 156) quiet_tail = 1;
        send_cand(rand_cand(i == batch_len - 1));
        n++;
      end
      if ($urandom_range(0, 5) == 0) begin
        @(negedge clk);
        cand.valid <= 1'b0;
        wait (expected_results.size() == 0);
      end
    end
    @(negedge clk);
    cand.valid <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
